[hdl/scpwm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scpwm_pkg
// Shared types and constants for the serial-commanded dual PWM motor drive.
// ----------------------------------------------------------------------------
package scpwm_pkg;

  localparam int LINE_CHARS = 16;   // bytes per line that are looked at
  localparam int PWM_STEPS  = 100;  // PWM period in ticks

  localparam int POS_W     = $clog2(LINE_CHARS + 1);
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_HEADER  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_HEADER = CFG_IDX_W'(1);

  localparam logic [7:0] LEFT_HEADER_RST  = 8'd76;  // 'L'
  localparam logic [7:0] RIGHT_HEADER_RST = 8'd82;  // 'R'

  localparam logic [7:0] DUTY_MAX = 8'd128;

  typedef enum logic [1:0] {
    DIR_FWD  = 2'd0,
    DIR_REV  = 2'd1,
    DIR_STOP = 2'd2
  } dir_t;

  typedef enum logic [1:0] {
    PH_BLANK  = 2'd0,
    PH_DIGITS = 2'd1,
    PH_DONE   = 2'd2
  } phase_t;

  typedef struct packed {
    logic       left_drive;
    logic       right_drive;
    logic [1:0] left_dir;
    logic [1:0] right_dir;
    logic [7:0] left_duty;
    logic [7:0] right_duty;
  } result_t;

endpackage

[hdl/scpwm_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scpwm_in_if
// Input channel: serial byte or PWM tick, valid/ready handshake.
// ----------------------------------------------------------------------------
interface scpwm_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] rx_byte;

  modport source (output valid, kind, rx_byte, input ready);
  modport sink   (input valid, kind, rx_byte, output ready);
endinterface

[hdl/scpwm_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scpwm_out_if
// Result channel: drive levels, directions and duties, valid/ready handshake.
// ----------------------------------------------------------------------------
interface scpwm_out_if;
  logic       valid;
  logic       ready;
  logic       left_drive;
  logic       right_drive;
  logic [1:0] left_dir;
  logic [1:0] right_dir;
  logic [7:0] left_duty;
  logic [7:0] right_duty;

  modport source (output valid, left_drive, right_drive, left_dir, right_dir,
                  left_duty, right_duty, input ready);
  modport sink   (input valid, left_drive, right_drive, left_dir, right_dir,
                  left_duty, right_duty, output ready);
endinterface

[hdl/scpwm_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scpwm_core
// Command line parser, channel registers and PWM counter; one word per fire.
// ----------------------------------------------------------------------------
module scpwm_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              fire,
  input  logic                              kind,
  input  logic [7:0]                        rx_byte,
  input  logic                              cfg_we,
  input  logic [scpwm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [scpwm_pkg::CFG_W-1:0]       cfg_data,
  output scpwm_pkg::result_t                res
);
  import scpwm_pkg::*;

  localparam logic [7:0]       STEP_LAST = 8'(PWM_STEPS - 1);
  localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(LINE_CHARS);

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  logic [7:0]       left_header, right_header;
  logic [7:0]       step_count, step_count_next;
  logic [7:0]       duty_left, duty_left_next;
  logic [7:0]       duty_right, duty_right_next;
  dir_t             dir_left, dir_left_next;
  dir_t             dir_right, dir_right_next;
  logic             pin_left, pin_left_next;
  logic             pin_right, pin_right_next;
  logic [POS_W-1:0] line_pos, line_pos_next;
  logic [7:0]       line_hdr, line_hdr_next;
  phase_t           phase, phase_next;
  logic             neg, neg_next;
  logic [7:0]       accum, accum_next;

  logic       is_blank, is_sign, is_digit;
  logic [7:0] digit_val, accum_step, line_value, value_mag;
  dir_t       value_dir;

  always_comb begin
    is_blank   = (rx_byte == CH_SPACE) || (rx_byte == CH_TAB) || (rx_byte == CH_LF) ||
                 (rx_byte == CH_VT) || (rx_byte == CH_FF);
    is_sign    = (rx_byte == CH_PLUS) || (rx_byte == CH_MINUS);
    is_digit   = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
    digit_val  = rx_byte - CH_ZERO;
    // accum * 10 + digit, modulo 256
    accum_step = {accum[4:0], 3'b000} + {accum[6:0], 1'b0} + digit_val;
    line_value = neg ? (8'd0 - accum) : accum;
    if (line_value == 8'd0) begin
      value_mag = 8'd0;
      value_dir = DIR_STOP;
    end else if (line_value[7]) begin
      value_mag = 8'd0 - line_value;
      value_dir = DIR_REV;
    end else begin
      value_mag = line_value;
      value_dir = DIR_FWD;
    end
  end

  always_comb begin
    step_count_next = step_count;
    duty_left_next  = duty_left;
    duty_right_next = duty_right;
    dir_left_next   = dir_left;
    dir_right_next  = dir_right;
    pin_left_next   = pin_left;
    pin_right_next  = pin_right;
    line_pos_next   = line_pos;
    line_hdr_next   = line_hdr;
    phase_next      = phase;
    neg_next        = neg;
    accum_next      = accum;

    if (kind) begin
      if (step_count == 8'd0) begin
        pin_left_next  = 1'b1;
        pin_right_next = 1'b1;
      end
      if (step_count == duty_left) pin_left_next = 1'b0;
      if (step_count == duty_right) pin_right_next = 1'b0;
      step_count_next = (step_count >= STEP_LAST) ? 8'd0 : step_count + 8'd1;
    end else if (rx_byte == CH_CR) begin
      // left wins when both headers match
      if (line_hdr == left_header) begin
        duty_left_next = value_mag;
        dir_left_next  = value_dir;
      end else if (line_hdr == right_header) begin
        duty_right_next = value_mag;
        dir_right_next  = value_dir;
      end
      line_pos_next = '0;
      line_hdr_next = 8'd0;
      phase_next    = PH_BLANK;
      neg_next      = 1'b0;
      accum_next    = 8'd0;
    end else begin
      if (line_pos == '0) begin
        line_hdr_next = rx_byte;
      end else if (line_pos < POS_LIMIT) begin
        case (phase)
          PH_BLANK: begin
            if (is_blank) begin
              phase_next = PH_BLANK;
            end else if (is_sign) begin
              neg_next   = (rx_byte == CH_MINUS);
              phase_next = PH_DIGITS;
            end else if (is_digit) begin
              accum_next = accum_step;
              phase_next = PH_DIGITS;
            end else begin
              phase_next = PH_DONE;
            end
          end
          PH_DIGITS: begin
            if (is_digit) accum_next = accum_step;
            else phase_next = PH_DONE;
          end
          default: begin
            phase_next = phase;
          end
        endcase
      end
      if (line_pos < POS_LIMIT) line_pos_next = line_pos + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_header  <= LEFT_HEADER_RST;
      right_header <= RIGHT_HEADER_RST;
      step_count   <= 8'd0;
      duty_left    <= 8'd0;
      duty_right   <= 8'd0;
      dir_left     <= DIR_STOP;
      dir_right    <= DIR_STOP;
      pin_left     <= 1'b0;
      pin_right    <= 1'b0;
      line_pos     <= '0;
      line_hdr     <= 8'd0;
      phase        <= PH_BLANK;
      neg          <= 1'b0;
      accum        <= 8'd0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_LEFT_HEADER:  left_header  <= cfg_data[7:0];
          REG_RIGHT_HEADER: right_header <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (fire) begin
        step_count <= step_count_next;
        duty_left  <= duty_left_next;
        duty_right <= duty_right_next;
        dir_left   <= dir_left_next;
        dir_right  <= dir_right_next;
        pin_left   <= pin_left_next;
        pin_right  <= pin_right_next;
        line_pos   <= line_pos_next;
        line_hdr   <= line_hdr_next;
        phase      <= phase_next;
        neg        <= neg_next;
        accum      <= accum_next;
      end
    end
  end

  always_comb begin
    res.left_drive  = pin_left_next;
    res.right_drive = pin_right_next;
    res.left_dir    = dir_left_next;
    res.right_dir   = dir_right_next;
    res.left_duty   = duty_left_next;
    res.right_duty  = duty_right_next;
  end

`ifndef SYNTHESIS
  a_duty_range: assert property (@(posedge clk) disable iff (rst)
    (duty_left <= DUTY_MAX) && (duty_right <= DUTY_MAX))
    else $error("duty above 128");

  a_stop_iff_zero: assert property (@(posedge clk) disable iff (rst)
    ((dir_left == DIR_STOP) == (duty_left == 8'd0)) &&
    ((dir_right == DIR_STOP) == (duty_right == 8'd0)))
    else $error("direction and duty disagree");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    step_count <= STEP_LAST)
    else $error("PWM counter out of period");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    line_pos <= POS_LIMIT)
    else $error("line position past limit");

  a_byte_keeps_count: assert property (@(posedge clk) disable iff (rst)
    (fire && !kind) |=> $stable(step_count))
    else $error("serial byte moved PWM counter");
`endif

endmodule

[hdl/serial_command_dual_pwm_motor_drive.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_command_dual_pwm_motor_drive
// Serial command lines set left/right duty and direction; ticks run the PWM.
// ----------------------------------------------------------------------------
//  channel  dir  width  contents
//  cmd      in   9      kind (0 byte, 1 tick), rx_byte
//  status   out  22     drive levels, dir codes, duties after the word
//  cfg      in   1+1+8  cfg_we, cfg_index, cfg_data (header registers)
//
// One word per cycle while status is not stalled. A word is taken into the
// input register and its result is then loaded into the result register,
// which drives status. The state update is short logic between the two. rst
// clears state and both handshakes; headers return to 'L' and 'R'.
// A stalled status word holds the pipeline; cmd.ready drops only when both
// registers are full and status.ready is low.
module serial_command_dual_pwm_motor_drive (
  input  logic                            clk,
  input  logic                            rst,
  scpwm_in_if.sink                        cmd,
  scpwm_out_if.source                     status,
  input  logic                            cfg_we,
  input  logic [scpwm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [scpwm_pkg::CFG_W-1:0]     cfg_data
);
  import scpwm_pkg::*;

  logic       in_valid;
  logic       in_kind;
  logic [7:0] in_byte;
  logic       out_valid;
  result_t    out_word;
  result_t    res;
  logic       out_free;
  logic       fire;

  assign out_free  = !out_valid || status.ready;
  assign fire      = in_valid && out_free;
  assign cmd.ready = !in_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (cmd.ready) begin
      in_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      in_kind <= cmd.kind;
      in_byte <= cmd.rx_byte;
    end
  end

  scpwm_core u_core (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .kind      (in_kind),
    .rx_byte   (in_byte),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) out_word <= res;
  end

  assign status.valid       = out_valid;
  assign status.left_drive  = out_word.left_drive;
  assign status.right_drive = out_word.right_drive;
  assign status.left_dir    = out_word.left_dir;
  assign status.right_dir   = out_word.right_dir;
  assign status.left_duty   = out_word.left_duty;
  assign status.right_duty  = out_word.right_duty;

endmodule

[tb/sv/serial_command_dual_pwm_motor_drive_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_command_dual_pwm_motor_drive_tb
// Feeds command lines and PWM ticks into the motor drive and compares every
// status word against a cycle-free model of the parser, duty registers and
// PWM counter. Runs directed lines, a full PWM period, output back-pressure
// and random traffic under several header register settings.
// ----------------------------------------------------------------------------
module serial_command_dual_pwm_motor_drive_tb;
  import scpwm_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  scpwm_in_if  cmd_if ();
  scpwm_out_if status_if ();

  serial_command_dual_pwm_motor_drive u_dut (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd_if),
    .status   (status_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // model state
  logic [7:0]  hdr_left_cfg = LEFT_HEADER_RST;
  logic [7:0]  hdr_right_cfg = RIGHT_HEADER_RST;
  logic [7:0]  pwm_step = 8'd0;
  logic [7:0]  duty_l = 8'd0;
  logic [7:0]  duty_r = 8'd0;
  dir_t        dir_l = DIR_STOP;
  dir_t        dir_r = DIR_STOP;
  logic        pin_l = 1'b0;
  logic        pin_r = 1'b0;
  int unsigned line_pos = 0;
  logic [7:0]  line_hdr = 8'd0;
  phase_t      num_phase = PH_BLANK;
  logic        num_neg = 1'b0;
  logic [7:0]  num_acc = 8'd0;

  result_t     pending_status[$];
  logic [8:0]  tx_queue[$];
  int unsigned words_queued = 0;
  int unsigned words_taken = 0;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  int unsigned rx_hold_req = 0;
  int unsigned rx_hold_left = 0;
  int unsigned tick_pct = 45;
  bit          tx_idle_en = 1'b1;
  bit          rx_stall_en = 1'b1;
  logic [7:0]  blank_chars [5] = '{CH_SP, CH_TAB, CH_LF, CH_VT, CH_FF};

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("serial_command_dual_pwm_motor_drive_tb failed");
      $finish;
    end
  end

  task automatic set_side(input logic [7:0] v, output logic [7:0] duty, output dir_t dir);
    if (v == 8'd0) begin
      duty = 8'd0;
      dir  = DIR_STOP;
    end else if (v[7]) begin
      duty = 8'd0 - v;  // -128 wraps to duty 128
      dir  = DIR_REV;
    end else begin
      duty = v;
      dir  = DIR_FWD;
    end
  endtask

  // advance the model by one accepted word and queue the status it causes
  task automatic update_drive_state(input logic k, input logic [7:0] c);
    logic [7:0] v;
    logic is_digit;
    logic is_blank;
    result_t r;
    is_digit = (c >= CH_0) && (c <= CH_9);
    is_blank = (c == CH_SP) || (c == CH_TAB) || (c == CH_LF) || (c == CH_VT) || (c == CH_FF);
    if (k) begin
      if (pwm_step == 8'd0) begin
        pin_l = 1'b1;
        pin_r = 1'b1;
      end
      if (pwm_step == duty_l) pin_l = 1'b0;
      if (pwm_step == duty_r) pin_r = 1'b0;
      pwm_step = (pwm_step + 1 >= PWM_STEPS) ? 8'd0 : pwm_step + 8'd1;
    end else if (c == CH_CR) begin
      v = num_neg ? 8'd0 - num_acc : num_acc;
      if (line_hdr == hdr_left_cfg) set_side(v, duty_l, dir_l);
      else if (line_hdr == hdr_right_cfg) set_side(v, duty_r, dir_r);
      line_pos  = 0;
      line_hdr  = 8'd0;
      num_phase = PH_BLANK;
      num_neg   = 1'b0;
      num_acc   = 8'd0;
    end else begin
      if (line_pos == 0) begin
        line_hdr = c;
      end else if (line_pos < LINE_CHARS) begin
        if (num_phase == PH_BLANK && (c == CH_PLUS || c == CH_MINUS)) begin
          num_neg   = (c == CH_MINUS);
          num_phase = PH_DIGITS;
        end else if (num_phase != PH_DONE && !(num_phase == PH_BLANK && is_blank)) begin
          if (is_digit) begin
            num_acc   = num_acc * 8'd10 + (c - CH_0);
            num_phase = PH_DIGITS;
          end else begin
            num_phase = PH_DONE;
          end
        end
      end
      if (line_pos < LINE_CHARS) line_pos++;
    end
    r.left_drive  = pin_l;
    r.right_drive = pin_r;
    r.left_dir    = dir_l;
    r.right_dir   = dir_r;
    r.left_duty   = duty_l;
    r.right_duty  = duty_r;
    pending_status.push_back(r);
  endtask

  // cmd driver: holds a word until taken, idles at random between words
  initial begin
    logic [8:0] w;
    cmd_if.valid   = 1'b0;
    cmd_if.kind    = 1'b0;
    cmd_if.rx_byte = 8'd0;
    forever begin
      @(posedge clk);
      if (!rst && cmd_if.valid && cmd_if.ready) begin
        update_drive_state(cmd_if.kind, cmd_if.rx_byte);
        words_taken++;
      end
      if (!(cmd_if.valid && !cmd_if.ready)) begin
        if (tx_queue.size() > 0 && !(tx_idle_en && $urandom_range(0, 99) < 7)) begin
          w = tx_queue.pop_front();
          cmd_if.valid   <= 1'b1;
          cmd_if.kind    <= w[8];
          cmd_if.rx_byte <= w[7:0];
        end else begin
          cmd_if.valid   <= 1'b0;
          cmd_if.rx_byte <= 8'($urandom);
        end
      end
    end
  end

  task automatic check_status();
    result_t want;
    if (pending_status.size() == 0) begin
      $error("status word with no expected result pending");
      fail_count++;
      return;
    end
    want = pending_status.pop_front();
    if (status_if.left_drive !== want.left_drive) begin
      $error("left_drive: expected %0d, got %0d", want.left_drive, status_if.left_drive);
      fail_count++;
    end
    if (status_if.right_drive !== want.right_drive) begin
      $error("right_drive: expected %0d, got %0d", want.right_drive, status_if.right_drive);
      fail_count++;
    end
    if (status_if.left_dir !== want.left_dir) begin
      $error("left_dir: expected %0d, got %0d", want.left_dir, status_if.left_dir);
      fail_count++;
    end
    if (status_if.right_dir !== want.right_dir) begin
      $error("right_dir: expected %0d, got %0d", want.right_dir, status_if.right_dir);
      fail_count++;
    end
    if (status_if.left_duty !== want.left_duty) begin
      $error("left_duty: expected %0d, got %0d", want.left_duty, status_if.left_duty);
      fail_count++;
    end
    if (status_if.right_duty !== want.right_duty) begin
      $error("right_duty: expected %0d, got %0d", want.right_duty, status_if.right_duty);
      fail_count++;
    end
  endtask

  // status sink: checks each word, stalls at random or for a requested hold
  initial begin
    status_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && status_if.valid && status_if.ready) check_status();
      if (rx_hold_req > 0) begin
        rx_hold_left = rx_hold_req;
        rx_hold_req  = 0;
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        status_if.ready <= 1'b0;
      end else begin
        status_if.ready <= !(rx_stall_en && $urandom_range(0, 99) < 7);
      end
    end
  end

  task automatic send_word(input logic k, input logic [7:0] c);
    while (tx_queue.size() >= 4) @(posedge clk);
    tx_queue.push_back({k, c});
    words_queued++;
  endtask

  // a serial byte, with PWM ticks mixed in ahead of it
  task automatic send_byte(input logic [7:0] c);
    while ($urandom_range(0, 99) < tick_pct) send_word(1'b1, 8'($urandom));
    send_word(1'b0, c);
  endtask

  task automatic send_line(input logic [7:0] hdr, input string body);
    send_byte(hdr);
    for (int i = 0; i < body.len(); i++) send_byte(body[i]);
    send_byte(CH_CR);
  endtask

  task automatic wait_idle();
    while (words_taken != words_queued || pending_status.size() != 0) @(posedge clk);
  endtask

  task automatic write_headers(input logic [7:0] left_val, input logic [7:0] right_val);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_LEFT_HEADER;
    cfg_data  <= left_val;
    @(posedge clk);
    cfg_index <= REG_RIGHT_HEADER;
    cfg_data  <= right_val;
    @(posedge clk);
    cfg_we <= 1'b0;
    hdr_left_cfg  = left_val;
    hdr_right_cfg = right_val;
  endtask

  function automatic logic [7:0] rand_non_cr();
    logic [7:0] b;
    do b = 8'($urandom); while (b == CH_CR);
    return b;
  endfunction

  // mostly well-formed lines with random content, some broken or overlong
  task automatic send_random_line();
    int sel;
    sel = $urandom_range(0, 7);
    if (sel == 7) begin
      send_byte(CH_CR);  // empty line
      return;
    end
    if (sel <= 2) send_byte(hdr_left_cfg);
    else if (sel <= 5) send_byte(hdr_right_cfg);
    else send_byte(rand_non_cr());
    repeat ($urandom_range(0, 2)) send_byte(blank_chars[$urandom_range(0, 4)]);
    case ($urandom_range(0, 3))
      0: send_byte(CH_MINUS);
      1: send_byte(CH_PLUS);
      default: ;
    endcase
    repeat ($urandom_range(0, 4)) send_byte(CH_0 + 8'($urandom_range(0, 9)));
    case ($urandom_range(0, 3))
      0: send_byte(CH_STAR);
      1: send_byte(rand_non_cr());
      2: begin
        // run past the line limit
        repeat ($urandom_range(8, 20)) begin
          if ($urandom_range(0, 1)) send_byte(CH_0 + 8'($urandom_range(0, 9)));
          else send_byte(rand_non_cr());
        end
      end
      default: ;
    endcase
    send_byte(CH_CR);
  endtask

  task automatic run_random(input int unsigned n);
    int unsigned target;
    target = words_queued + n;
    while (words_queued < target) begin
      if ($urandom_range(0, 99) < 15) repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
      else send_random_line();
    end
  endtask

  task automatic test_line_parsing();
    tick_pct = 0;
    send_line("L", "-128");
    send_line("R", "\t+7*");
    send_byte(CH_CR);
    send_line("L", "\n\v12 3");
    send_line("R", "x");
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(CH_CR);
    send_line("R", "999");
    wait_idle();
  endtask

  task automatic test_pwm_period();
    tick_pct = 0;
    send_line("L", "40");
    send_line("R", "-99");
    repeat (205) send_word(1'b1, 8'($urandom));
    send_line("R", "100");
    send_line("L", "0");
    repeat (110) send_word(1'b1, 8'($urandom));
    wait_idle();
  endtask

  task automatic test_backpressure();
    tick_pct = 30;
    rx_hold_req = 300;
    run_random(60);
    wait_idle();
  endtask

  task automatic test_header_settings();
    tick_pct = 45;
    run_random(70);
    write_headers(8'h00, 8'hFF);
    run_random(70);
    write_headers(8'hFF, 8'h00);
    run_random(70);
    write_headers(CH_STAR, CH_STAR);
    run_random(70);
    tx_idle_en  = 1'b0;
    rx_stall_en = 1'b0;
    write_headers(8'h41, CH_SP);
    run_random(100);
    tx_idle_en  = 1'b1;
    rx_stall_en = 1'b1;
    write_headers(LEFT_HEADER_RST, RIGHT_HEADER_RST);
    run_random(40);
    wait_idle();
  endtask

  initial begin
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = REG_LEFT_HEADER;
    cfg_data  = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_line_parsing();
    test_pwm_period();
    test_backpressure();
    test_header_settings();

    wait_idle();
    repeat (10) @(posedge clk);
    if (fail_count == 0) $display("serial_command_dual_pwm_motor_drive_tb passed");
    else $display("serial_command_dual_pwm_motor_drive_tb failed");
    $finish;
  end

endmodule
